// File: src/cbte_pkg.sv
// Shared types, constants and helper functions for the CABAC bypass/terminate encoder.
// No dependencies; the encoder top and the testbench refer to this package by scoped names.
`default_nettype none

package cbte_pkg;

    localparam int MAX_PENDING_DEF = 32;
    localparam int RES_CAP         = 48;
    localparam int MEM_AW          = 6;

    localparam logic [2:0] CMD_BYPASS = 3'd0;
    localparam logic [2:0] CMD_TERM   = 3'd1;
    localparam logic [2:0] CMD_LEVEL  = 3'd2;
    localparam logic [2:0] CMD_FINISH = 3'd3;
    localparam logic [2:0] CMD_START  = 3'd4;

    localparam logic CFG_LPM  = 1'b0;
    localparam logic CFG_MLDR = 1'b1;

    localparam logic [8:0] RANGE_INIT  = 9'd510;
    localparam logic [4:0] BUDGET_INIT = 5'd23;
    localparam logic [4:0] SETTLE_LIM  = 5'd12;
    localparam logic [4:0] MLDR_INIT   = 5'd15;
    localparam logic [3:0] RICE_MAX    = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DECODE,
        ST_LVL_EG,
        ST_LVL_LP,
        ST_LVL_SEG,
        ST_BYP,
        ST_SETTLE,
        ST_FILL,
        ST_FIN_A,
        ST_FIN_FILL,
        ST_FIN_TAIL,
        ST_DONE,
        ST_RD,
        ST_OUT
    } t_state;

    // Golomb-Rice prefix span per Rice parameter
    function automatic logic [2:0] rice_span(input logic [3:0] r);
        logic [2:0] s;
        unique case (r)
            4'd0:    s = 3'd6;
            4'd1:    s = 3'd5;
            4'd2:    s = 3'd6;
            default: s = 3'd3;
        endcase
        return s;
    endfunction

    function automatic logic [63:0] low_mask64(input logic [5:0] n);
        return (64'd1 << n) - 64'd1;
    endfunction

endpackage

`default_nettype wire

// File: src/cbte_if.sv
// Valid/ready channel interfaces for command items and coded-byte items.
// Stand-alone; no package dependency.
`default_nettype none

interface cbte_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic [31:0] bin_value;
    logic [5:0]  bin_count;
    logic [3:0]  rice_param;

    modport source(output valid, command, bin_value, bin_count, rice_param, input ready);
    modport sink(input valid, command, bin_value, bin_count, rice_param, output ready);
endinterface

interface cbte_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;
    logic       outstanding_overflow;

    modport source(output valid, out_byte, last_of_run, outstanding_overflow, input ready);
    modport sink(input valid, out_byte, last_of_run, outstanding_overflow, output ready);
endinterface

`default_nettype wire

// File: src/cabac_bypass_terminate_encoder.sv
// Top level: CABAC bypass/terminate/remaining-level arithmetic encoder engine.
// Depends on cbte_pkg and the channel interfaces in cbte_if.sv.
//
//  channel   dir  handshake       payload
//  i_item    in   valid/ready     command, bin_value, bin_count, rice_param
//  o_res     out  valid/ready     out_byte, last_of_run, outstanding_overflow
//  i_cfg_*   in   write enable    i_cfg_idx selects register, i_cfg_data value
//
// One item at a time. Each item is captured and decoded, then coded in 8-bin
// chunks through the shared low/range update, settling bytes and flushing
// outstanding bytes in between; escape-length searches step once per length.
// Bytes are buffered in a 48-entry memory and drained through a registered read.
// Synchronous active-low reset; output stalls simply hold the drain.
`default_nettype none

module cabac_bypass_terminate_encoder #(
    parameter int MAX_PENDING = cbte_pkg::MAX_PENDING_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    cbte_in_if.sink     i_item,
    cbte_out_if.source  o_res,
    input  wire         i_cfg_we,
    input  wire         i_cfg_idx,
    input  wire  [4:0]  i_cfg_data
);

    cbte_pkg::t_state r_state, n_state;

    logic        r_lpm;
    logic [4:0]  r_mldr;
    logic [31:0] r_low, n_low;
    logic [8:0]  r_range, n_range;
    logic [4:0]  r_budget, n_budget;
    logic [7:0]  r_held, n_held;
    logic [5:0]  r_pending, n_pending;
    logic        r_sat, n_sat;

    logic [2:0]  r_cmd, n_cmd;
    logic [31:0] r_value, n_value;
    logic [5:0]  r_count, n_count;
    logic [3:0]  r_rice, n_rice;

    logic [63:0] r_seg_pat, n_seg_pat, r_seg2_pat, n_seg2_pat;
    logic [5:0]  r_seg_cnt, n_seg_cnt, r_seg2_cnt, n_seg2_cnt;
    logic [7:0]  r_fill, n_fill;
    logic [31:0] r_cv, n_cv;
    logic [4:0]  r_p, n_p;
    logic [5:0]  r_sl, n_sl;
    logic [31:0] r_rest, n_rest;
    logic [5:0]  r_len, n_len;
    logic [2:0]  r_tail, n_tail;

    logic [cbte_pkg::MEM_AW-1:0] r_wcnt, n_wcnt, r_rptr, n_rptr;
    logic [7:0]  r_rdata;
    logic [7:0]  mem [cbte_pkg::RES_CAP];

    logic        n_we;
    logic [7:0]  n_wbyte;

    // derived values
    logic [3:0]  rice_eff;
    logic [2:0]  span3;
    logic [11:0] thr;
    logic [31:0] rmask;
    logic [4:0]  ml_sat, maxp;
    logic [3:0]  k;
    logic [5:0]  cnt_after;
    logic [7:0]  chunk;
    logic [16:0] prod;
    logic [31:0] low_byp;
    logic [4:0]  budget_byp;
    logic [31:0] lead;
    logic [7:0]  carry8;
    logic [4:0]  budget_s;
    logic        last;

    always_comb begin
        rice_eff   = (r_rice > cbte_pkg::RICE_MAX) ? cbte_pkg::RICE_MAX : r_rice;
        span3      = cbte_pkg::rice_span(rice_eff);
        thr        = 12'(span3) << rice_eff;
        rmask      = (32'd1 << rice_eff) - 32'd1;
        if (r_mldr == 5'd0) begin
            ml_sat = 5'd1;
        end else if (r_mldr > 5'd28) begin
            ml_sat = 5'd28;
        end else begin
            ml_sat = r_mldr;
        end
        maxp       = 5'(5'd29 - ml_sat);
        k          = (r_seg_cnt > 6'd8) ? 4'd8 : r_seg_cnt[3:0];
        cnt_after  = r_seg_cnt - 6'(k);
        chunk      = 8'((r_seg_pat >> cnt_after) & cbte_pkg::low_mask64(6'(k)));
        prod       = r_range * chunk;
        low_byp    = (r_low << k) + 32'(prod);
        budget_byp = r_budget - 5'(k);
        lead       = r_low >> 5'(5'd24 - r_budget);
        carry8     = lead[15:8];
        budget_s   = r_budget + 5'd8;
        last       = (r_rptr == r_wcnt - cbte_pkg::MEM_AW'(1));
    end

    always_comb begin
        logic [8:0]  rng2;
        logic [31:0] cv;
        logic [32:0] delta;
        logic [5:0]  nbin;
        logic [5:0]  lenv;
        logic [4:0]  sh;
        logic [31:0] low2;
        logic [4:0]  b2;
        logic [5:0]  toff;
        logic [4:0]  tspan;
        logic [63:0] suf;

        n_state    = r_state;
        n_low      = r_low;
        n_range    = r_range;
        n_budget   = r_budget;
        n_held     = r_held;
        n_pending  = r_pending;
        n_sat      = r_sat;
        n_cmd      = r_cmd;
        n_value    = r_value;
        n_count    = r_count;
        n_rice     = r_rice;
        n_seg_pat  = r_seg_pat;
        n_seg_cnt  = r_seg_cnt;
        n_seg2_pat = r_seg2_pat;
        n_seg2_cnt = r_seg2_cnt;
        n_fill     = r_fill;
        n_cv       = r_cv;
        n_p        = r_p;
        n_sl       = r_sl;
        n_rest     = r_rest;
        n_len      = r_len;
        n_tail     = r_tail;
        n_wcnt     = r_wcnt;
        n_rptr     = r_rptr;
        n_we       = 1'b0;
        n_wbyte    = 8'd0;

        rng2  = r_range - 9'd2;
        cv    = (r_value >> rice_eff) - 32'd3;
        delta = 33'd1 << r_len;
        nbin  = 6'(span3) + r_len + 6'd1 - 6'(rice_eff);
        lenv  = 6'((r_value >> rice_eff) + 32'd1);
        sh    = 5'(6'd32 - 6'(r_budget));
        low2  = ((r_low >> 8) << 1) + 32'd1;
        b2    = r_budget - 5'd1;
        toff  = {r_tail, 3'b000};
        tspan = 5'(5'd24 - r_budget);
        suf   = ((64'(r_cv) - ((64'd1 << r_p) - 64'd1)) << rice_eff)
                | 64'(r_value & rmask);

        i_item.ready = (r_state == cbte_pkg::ST_IDLE);

        unique case (r_state)
            cbte_pkg::ST_IDLE: begin
                if (i_item.valid) begin
                    n_cmd   = i_item.command;
                    n_value = i_item.bin_value;
                    n_count = i_item.bin_count;
                    n_rice  = i_item.rice_param;
                    n_wcnt  = '0;
                    n_state = cbte_pkg::ST_DECODE;
                end
            end
            cbte_pkg::ST_DECODE: begin
                n_seg_cnt  = '0;
                n_seg2_cnt = '0;
                n_state    = cbte_pkg::ST_DONE;
                priority if (r_cmd == cbte_pkg::CMD_BYPASS) begin
                    n_seg_cnt = (r_count > 6'd32) ? 6'd32 : r_count;
                    n_seg_pat = 64'(r_value) & cbte_pkg::low_mask64(n_seg_cnt);
                    n_state   = cbte_pkg::ST_BYP;
                end else if (r_cmd == cbte_pkg::CMD_TERM) begin
                    if (r_value[0]) begin
                        n_low    = (r_low + 32'(rng2)) << 7;
                        n_range  = 9'd256;
                        n_budget = r_budget - 5'd7;
                    end else if (rng2 >= 9'd256) begin
                        n_range  = rng2;
                    end else begin
                        n_low    = r_low << 1;
                        n_range  = rng2 << 1;
                        n_budget = r_budget - 5'd1;
                    end
                    if (n_budget < cbte_pkg::SETTLE_LIM) begin
                        n_state = cbte_pkg::ST_SETTLE;
                    end
                end else if (r_cmd == cbte_pkg::CMD_LEVEL) begin
                    if (r_value < 32'(thr)) begin
                        n_seg_pat  = cbte_pkg::low_mask64(lenv) - 64'd1;
                        n_seg_cnt  = lenv;
                        n_seg2_pat = 64'(r_value & rmask);
                        n_seg2_cnt = 6'(rice_eff);
                        n_state    = cbte_pkg::ST_BYP;
                    end else if (r_lpm) begin
                        n_cv = cv;
                        if (33'(cv) >= (33'd1 << maxp) - 33'd1) begin
                            n_p     = maxp;
                            n_sl    = 6'(ml_sat);
                            n_state = cbte_pkg::ST_LVL_SEG;
                        end else begin
                            n_p     = '0;
                            n_state = cbte_pkg::ST_LVL_LP;
                        end
                    end else begin
                        n_rest  = r_value - 32'(thr);
                        n_len   = 6'(rice_eff);
                        n_state = cbte_pkg::ST_LVL_EG;
                    end
                end else if (r_cmd == cbte_pkg::CMD_FINISH) begin
                    n_state = cbte_pkg::ST_FIN_A;
                end else if (r_cmd == cbte_pkg::CMD_START) begin
                    n_low     = '0;
                    n_range   = cbte_pkg::RANGE_INIT;
                    n_budget  = cbte_pkg::BUDGET_INIT;
                    n_held    = '0;
                    n_pending = '0;
                    n_sat     = 1'b0;
                end else begin
                    n_state = cbte_pkg::ST_DONE;
                end
            end
            cbte_pkg::ST_LVL_EG: begin
                // Exp-Golomb escape: find suffix length one step a cycle
                if (33'(r_rest) >= delta) begin
                    n_rest = 32'(33'(r_rest) - delta);
                    n_len  = r_len + 6'd1;
                end else begin
                    n_seg_pat  = cbte_pkg::low_mask64(nbin) - 64'd1;
                    n_seg_cnt  = nbin;
                    n_seg2_pat = 64'(r_rest) & cbte_pkg::low_mask64(r_len);
                    n_seg2_cnt = r_len;
                    n_state    = cbte_pkg::ST_BYP;
                end
            end
            cbte_pkg::ST_LVL_LP: begin
                if (33'(r_cv) > (33'd2 << r_p) - 33'd2) begin
                    n_p = r_p + 5'd1;
                end else begin
                    n_sl    = 6'(r_p) + 6'(rice_eff) + 6'd1;
                    n_state = cbte_pkg::ST_LVL_SEG;
                end
            end
            cbte_pkg::ST_LVL_SEG: begin
                n_seg_cnt  = 6'(r_p) + 6'd3;
                n_seg_pat  = cbte_pkg::low_mask64(n_seg_cnt);
                n_seg2_pat = suf & cbte_pkg::low_mask64(r_sl);
                n_seg2_cnt = r_sl;
                n_state    = cbte_pkg::ST_BYP;
            end
            cbte_pkg::ST_BYP: begin
                if (r_seg_cnt != 6'd0) begin
                    n_low     = low_byp;
                    n_budget  = budget_byp;
                    n_seg_cnt = cnt_after;
                    if (budget_byp < cbte_pkg::SETTLE_LIM) begin
                        n_state = cbte_pkg::ST_SETTLE;
                    end
                end else if (r_seg2_cnt != 6'd0) begin
                    n_seg_pat  = r_seg2_pat;
                    n_seg_cnt  = r_seg2_cnt;
                    n_seg2_cnt = '0;
                end else begin
                    n_state = cbte_pkg::ST_DONE;
                end
            end
            cbte_pkg::ST_SETTLE: begin
                n_budget = budget_s;
                n_low    = r_low & (32'hffff_ffff >> budget_s);
                n_state  = cbte_pkg::ST_BYP;
                if (lead == 32'h0000_00ff) begin
                    if (r_pending == 6'd0) begin
                        n_held    = 8'hff;
                        n_pending = 6'd1;
                    end else if (r_pending < 6'(MAX_PENDING)) begin
                        n_pending = r_pending + 6'd1;
                    end else begin
                        n_sat = 1'b1;
                    end
                end else if (r_pending != 6'd0) begin
                    n_we    = 1'b1;
                    n_wbyte = r_held + carry8;
                    n_held  = lead[7:0];
                    n_fill  = 8'hff + carry8;
                    n_state = cbte_pkg::ST_FILL;
                end else begin
                    n_pending = 6'd1;
                    n_held    = lead[7:0];
                end
            end
            cbte_pkg::ST_FILL: begin
                if (r_pending > 6'd1) begin
                    n_we      = 1'b1;
                    n_wbyte   = r_fill;
                    n_pending = r_pending - 6'd1;
                end else begin
                    n_state = cbte_pkg::ST_BYP;
                end
            end
            cbte_pkg::ST_FIN_A: begin
                if ((r_low >> sh) != 32'd0) begin
                    n_we    = 1'b1;
                    n_wbyte = r_held + 8'd1;
                    n_fill  = 8'h00;
                    n_low   = r_low - (32'd1 << sh);
                end else begin
                    n_we    = (r_pending != 6'd0);
                    n_wbyte = r_held;
                    n_fill  = 8'hff;
                end
                n_state = cbte_pkg::ST_FIN_FILL;
            end
            cbte_pkg::ST_FIN_FILL: begin
                if (r_pending > 6'd1) begin
                    n_we      = 1'b1;
                    n_wbyte   = r_fill;
                    n_pending = r_pending - 6'd1;
                end else begin
                    n_low    = low2 << 5'(5'd8 + b2);
                    n_budget = b2;
                    n_tail   = '0;
                    n_state  = cbte_pkg::ST_FIN_TAIL;
                end
            end
            cbte_pkg::ST_FIN_TAIL: begin
                if (r_tail <= 3'd3 && toff < 6'(tspan)) begin
                    n_we    = 1'b1;
                    n_wbyte = 8'(r_low >> (6'd24 - toff));
                    n_tail  = r_tail + 3'd1;
                end else begin
                    n_low     = '0;
                    n_range   = cbte_pkg::RANGE_INIT;
                    n_budget  = cbte_pkg::BUDGET_INIT;
                    n_held    = '0;
                    n_pending = '0;
                    n_state   = cbte_pkg::ST_DONE;
                end
            end
            cbte_pkg::ST_DONE: begin
                n_rptr  = '0;
                n_state = (r_wcnt == '0) ? cbte_pkg::ST_IDLE : cbte_pkg::ST_RD;
            end
            cbte_pkg::ST_RD: begin
                n_state = cbte_pkg::ST_OUT;
            end
            cbte_pkg::ST_OUT: begin
                if (o_res.ready) begin
                    if (last) begin
                        n_state = cbte_pkg::ST_IDLE;
                    end else begin
                        n_rptr  = r_rptr + cbte_pkg::MEM_AW'(1);
                        n_state = cbte_pkg::ST_RD;
                    end
                end
            end
            default: begin
                n_state = cbte_pkg::ST_IDLE;
            end
        endcase

        // bytes past the buffer depth are dropped
        if (n_we && r_wcnt < cbte_pkg::MEM_AW'(cbte_pkg::RES_CAP)) begin
            n_wcnt = r_wcnt + cbte_pkg::MEM_AW'(1);
        end
    end

    assign o_res.valid                = (r_state == cbte_pkg::ST_OUT);
    assign o_res.out_byte             = r_rdata;
    assign o_res.last_of_run          = last;
    assign o_res.outstanding_overflow = r_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cbte_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low     <= '0;
            r_range   <= cbte_pkg::RANGE_INIT;
            r_budget  <= cbte_pkg::BUDGET_INIT;
            r_held    <= '0;
            r_pending <= '0;
            r_sat     <= 1'b0;
            r_wcnt    <= '0;
            r_rptr    <= '0;
        end else begin
            r_low     <= n_low;
            r_range   <= n_range;
            r_budget  <= n_budget;
            r_held    <= n_held;
            r_pending <= n_pending;
            r_sat     <= n_sat;
            r_wcnt    <= n_wcnt;
            r_rptr    <= n_rptr;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_value    <= n_value;
        r_count    <= n_count;
        r_rice     <= n_rice;
        r_seg_pat  <= n_seg_pat;
        r_seg_cnt  <= n_seg_cnt;
        r_seg2_pat <= n_seg2_pat;
        r_seg2_cnt <= n_seg2_cnt;
        r_fill     <= n_fill;
        r_cv       <= n_cv;
        r_p        <= n_p;
        r_sl       <= n_sl;
        r_rest     <= n_rest;
        r_len      <= n_len;
        r_tail     <= n_tail;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lpm  <= 1'b0;
            r_mldr <= cbte_pkg::MLDR_INIT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                cbte_pkg::CFG_LPM:  r_lpm  <= i_cfg_data[0];
                cbte_pkg::CFG_MLDR: r_mldr <= i_cfg_data;
                default:            r_lpm  <= r_lpm;
            endcase
        end
    end

    // byte buffer: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (n_we && r_wcnt < cbte_pkg::MEM_AW'(cbte_pkg::RES_CAP)) begin
            mem[r_wcnt] <= n_wbyte;
        end
        if (r_state == cbte_pkg::ST_RD) begin
            r_rdata <= mem[r_rptr];
        end
    end

endmodule

`default_nettype wire

// File: src/cbte_checker.sv
// Port-level checker for cabac_bypass_terminate_encoder, bound to the top level.
// Depends only on the top level's port signals.
`default_nettype none

module cbte_checker (
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       in_valid,
    input wire       in_ready,
    input wire       out_valid,
    input wire       out_ready,
    input wire       out_last,
    input wire [7:0] out_byte
);

    // never draining and accepting at once
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(in_ready && out_valid))
        else $error("input ready while output item pending");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("ready stayed high after an item was accepted");

    a_more_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_last |=> !in_ready)
        else $error("returned to idle before last byte");

    a_idle_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ready && !in_valid |=> in_ready && !out_valid)
        else $error("left idle without an item");

    a_hold_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_byte))
        else $error("stalled output byte changed");

endmodule

bind cabac_bypass_terminate_encoder cbte_checker u_cbte_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_item.valid),
    .in_ready  (i_item.ready),
    .out_valid (o_res.valid),
    .out_ready (o_res.ready),
    .out_last  (o_res.last_of_run),
    .out_byte  (o_res.out_byte)
);

`default_nettype wire

// File: tb/cabac_bypass_terminate_encoder_tb.sv
// Testbench for the CABAC bypass/terminate/remaining-level encoder engine.
// Needs cbte_pkg, cbte_if.sv and the encoder top; predicts the coded bytes and checks them in order.
`default_nettype none

module cabac_bypass_terminate_encoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 400;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] bin_value;
        logic [5:0]  bin_count;
        logic [3:0]  rice_param;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
        logic       overflow;
    } t_coded;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = 1'b0;
    logic [4:0] i_cfg_data = '0;

    cbte_in_if  cmd_ch();
    cbte_out_if byte_ch();

    cabac_bypass_terminate_encoder i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_item(cmd_ch.sink), .o_res(byte_ch.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // predictor state
    logic        lpm_q;
    logic [4:0]  mldr_q;
    logic [31:0] low_q;
    logic [31:0] rng_q;
    logic [31:0] budget_q;
    logic [7:0]  held_q;
    int          pend_q;
    logic        sat_q;
    logic [7:0]  step_bytes[$];
    t_coded      expected_bytes[$];

    t_cmd pending_cmds[$];
    int   mismatches = 0;
    int   watchdog = 0;
    int   accepted_cmds = 0;
    bit   hold_off = 1'b0;
    bit   in_acc = 1'b0;

    function automatic void push_byte(input logic [31:0] b);
        if (step_bytes.size() < cbte_pkg::RES_CAP) step_bytes.insert(step_bytes.size(), b[7:0]);
    endfunction

    function automatic void add_cmd(input t_cmd c);
        pending_cmds.insert(pending_cmds.size(), c);
    endfunction

    function automatic void engine_clear();
        low_q = 0; rng_q = 510; budget_q = 23; held_q = 8'd0; pend_q = 0;
    endfunction

    function automatic void settle();
        logic [31:0] lead, carry, fill;
        lead = low_q >> ((24 - budget_q) & 31);
        budget_q += 8;
        low_q &= 32'hffffffff >> (budget_q & 31);
        if (lead == 32'hff) begin
            if (pend_q == 0) begin
                held_q = 8'hff; pend_q = 1;
            end else if (pend_q < cbte_pkg::MAX_PENDING_DEF) begin
                pend_q++;
            end else begin
                sat_q = 1'b1;
            end
        end else if (pend_q > 0) begin
            carry = lead >> 8;
            fill = (32'hff + carry) & 32'hff;
            push_byte({24'd0, held_q} + carry);
            held_q = lead[7:0];
            while (pend_q > 1) begin
                push_byte(fill);
                pend_q--;
            end
        end else begin
            pend_q = 1;
            held_q = lead[7:0];
        end
    endfunction

    function automatic void code_bypass(input logic [63:0] pat, input int cnt);
        int k;
        logic [31:0] chunk;
        if (cnt > 63) cnt = 63;
        pat &= (64'd1 << cnt) - 64'd1;
        while (cnt > 0) begin
            k = cnt > 8 ? 8 : cnt;
            cnt -= k;
            chunk = 32'(pat >> cnt) & ((32'd1 << k) - 1);
            low_q = (low_q << k) + rng_q * chunk;
            budget_q -= k;
            if (budget_q < 12) settle();
        end
    endfunction

    function automatic void code_terminate(input logic bin);
        rng_q -= 2;
        if (bin) begin
            low_q += rng_q;
            low_q <<= 7;
            rng_q = 2 << 7;
            budget_q -= 7;
        end else if (rng_q >= 256) begin
            return;
        end else begin
            low_q <<= 1; rng_q <<= 1; budget_q -= 1;
        end
        if (budget_q < 12) settle();
    endfunction

    function automatic void code_level(input logic [31:0] value, input int r);
        int span, ml, maxp, p, sl, len, nbin;
        logic [31:0] thr, msk;
        logic [63:0] cv, suffix, rest, delta;
        if (r > 9) r = 9;
        span = (r == 0 || r == 2) ? 6 : (r == 1) ? 5 : 3;
        thr = span << r;
        msk = (32'd1 << r) - 1;
        if (value < thr) begin
            len = (value >> r) + 1;
            code_bypass((64'd1 << len) - 2, len);
            code_bypass(value & msk, r);
        end else if (lpm_q) begin
            ml = mldr_q;
            if (ml < 1) ml = 1;
            if (ml > 28) ml = 28;
            maxp = 29 - ml;
            cv = 64'(value >> r) - 3;
            if (cv >= (64'd1 << maxp) - 1) begin
                p = maxp; sl = ml;
            end else begin
                p = 0;
                while (cv > (64'd2 << p) - 2) p++;
                sl = p + r + 1;
            end
            code_bypass((64'd1 << (p + 3)) - 1, p + 3);
            suffix = ((cv - ((64'd1 << p) - 1)) << r) | 64'(value & msk);
            code_bypass(suffix, sl);
        end else begin
            len = r;
            rest = 64'(value - thr);
            delta = 64'd1 << len;
            while (rest >= delta) begin
                rest -= delta; len++; delta = 64'd1 << len;
            end
            nbin = span + len + 1 - r;
            code_bypass((64'd1 << nbin) - 2, nbin);
            code_bypass(rest, len);
        end
    endfunction

    function automatic void flush_stream();
        logic [31:0] sh, tail;
        sh = (32 - budget_q) & 31;
        if ((low_q >> sh) != 0) begin
            push_byte({24'd0, held_q} + 1);
            while (pend_q > 1) begin
                push_byte(0); pend_q--;
            end
            low_q -= 32'd1 << sh;
        end else begin
            if (pend_q > 0) push_byte({24'd0, held_q});
            while (pend_q > 1) begin
                push_byte(32'hff); pend_q--;
            end
        end
        low_q = ((low_q >> 8) << 1) + 1;
        budget_q -= 1;
        low_q <<= (8 + budget_q) & 31;
        tail = 24 - budget_q;
        for (int i = 0; i < tail && i <= 24; i += 8) push_byte(low_q >> (24 - i));
        engine_clear();
    endfunction

    function automatic void predict_bytes(input t_cmd c);
        int n;
        step_bytes.delete();
        case (c.command)
            cbte_pkg::CMD_BYPASS: code_bypass(64'(c.bin_value), c.bin_count > 32 ? 32 : c.bin_count);
            cbte_pkg::CMD_TERM:   code_terminate(c.bin_value[0]);
            cbte_pkg::CMD_LEVEL:  code_level(c.bin_value, c.rice_param);
            cbte_pkg::CMD_FINISH: flush_stream();
            cbte_pkg::CMD_START: begin
                engine_clear(); sat_q = 1'b0;
            end
            default: ;
        endcase
        n = step_bytes.size();
        for (int k = 0; k < n; k++)
            expected_bytes.insert(expected_bytes.size(), '{step_bytes[k], k == n - 1, sat_q});
    endfunction

    // driver: bursts with random gaps
    int burst_left = 0;
    int gap_left = 0;
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            cmd_ch.valid <= 1'b0;
        end else if (cmd_ch.valid && !in_acc) begin
            // hold the item until taken
        end else if (gap_left > 0 || hold_off || pending_cmds.size() == 0) begin
            cmd_ch.valid <= 1'b0;
            if (gap_left > 0) gap_left--;
        end else begin
            t_cmd c;
            c = pending_cmds.pop_front();
            cmd_ch.valid <= 1'b1;
            cmd_ch.command <= c.command;
            cmd_ch.bin_value <= c.bin_value;
            cmd_ch.bin_count <= c.bin_count;
            cmd_ch.rice_param <= c.rice_param;
            if (burst_left > 0) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(0, 8);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            end
        end
    end

    // receiver stalls on its own pattern
    int stall_phase = 0;
    always @(negedge i_clk) begin
        stall_phase <= stall_phase + 1;
        if ((stall_phase % 200) < 60) byte_ch.ready <= 1'b1;
        else byte_ch.ready <= ($urandom_range(0, 3) != 0);
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            in_acc <= cmd_ch.valid && cmd_ch.ready;
            if ((cmd_ch.valid && cmd_ch.ready) || (byte_ch.valid && byte_ch.ready))
                watchdog <= 0;
            else
                watchdog <= watchdog + 1;
            if (cmd_ch.valid && cmd_ch.ready) begin
                t_cmd c;
                c = '{cmd_ch.command, cmd_ch.bin_value, cmd_ch.bin_count, cmd_ch.rice_param};
                predict_bytes(c);
                accepted_cmds <= accepted_cmds + 1;
            end
            if (byte_ch.valid && byte_ch.ready) begin
                t_coded got, exp_b;
                got = '{byte_ch.out_byte, byte_ch.last_of_run, byte_ch.outstanding_overflow};
                if (expected_bytes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected byte %h", got.out_byte);
                end else begin
                    exp_b = expected_bytes.pop_front();
                    if (got !== exp_b) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("byte mismatch: exp %h last %b ovf %b, got %h last %b ovf %b",
                                exp_b.out_byte, exp_b.last_of_run, exp_b.overflow,
                                got.out_byte, got.last_of_run, got.overflow);
                    end
                end
            end
            if (watchdog >= WATCHDOG_LIMIT) begin
                $display("cabac_bypass_terminate_encoder_tb failed");
                $finish;
            end
        end
    end

    function automatic t_cmd mk(input logic [2:0] op, input logic [31:0] v,
                                input logic [5:0] n, input logic [3:0] r);
        return '{op, v, n, r};
    endfunction

    function automatic t_cmd rand_cmd();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 40)
            return mk(cbte_pkg::CMD_BYPASS, $urandom,
                      6'($urandom_range(0, 3) == 0 ? $urandom_range(0, 63)
                      : $urandom_range(1, 32)), 4'($urandom));
        else if (sel < 55)
            return mk(cbte_pkg::CMD_TERM, $urandom, 6'($urandom), 4'($urandom));
        else if (sel < 85)
            return mk(cbte_pkg::CMD_LEVEL,
                      $urandom_range(0, 1) ? $urandom_range(0, 200) : $urandom,
                      6'($urandom), 4'($urandom_range(0, 4) == 0 ? $urandom_range(0, 15)
                      : $urandom_range(0, 9)));
        else if (sel < 93)
            return mk(cbte_pkg::CMD_FINISH, $urandom, 6'($urandom), 4'($urandom));
        else if (sel < 97)
            return mk(cbte_pkg::CMD_START, $urandom, 6'($urandom), 4'($urandom));
        else return mk(3'($urandom_range(5, 7)), $urandom, 6'($urandom), 4'($urandom));
    endfunction

    task automatic wait_idle();
        while (pending_cmds.size() != 0 || cmd_ch.valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [4:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1; i_cfg_idx <= idx; i_cfg_data <= val;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == cbte_pkg::CFG_LPM) lpm_q = val[0];
        else mldr_q = val;
    endtask

    initial begin
        cmd_ch.valid = 1'b0;
        cmd_ch.command = '0;
        cmd_ch.bin_value = '0;
        cmd_ch.bin_count = '0;
        cmd_ch.rice_param = '0;
        byte_ch.ready = 1'b0;
        lpm_q = 1'b0; mldr_q = cbte_pkg::MLDR_INIT; sat_q = 1'b0;
        engine_clear();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: extremes, every command, special cases
        add_cmd(mk(cbte_pkg::CMD_BYPASS, 32'hffffffff, 6'd32, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_BYPASS, 32'h0, 6'd32, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_BYPASS, 32'hdeadbeef, 6'd63, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_BYPASS, 32'h12345678, 6'd0, 4'hf));
        add_cmd(mk(cbte_pkg::CMD_TERM, 32'h0, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_TERM, 32'hfffffffe, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_TERM, 32'h1, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'd0, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'd5, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'd3000, 6'd0, 4'd9));
        add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'hffffffff, 6'h3f, 4'd15));
        add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'd100, 6'd0, 4'd2));
        add_cmd(mk(3'd5, 32'hffffffff, 6'h3f, 4'hf));
        add_cmd(mk(3'd7, 32'd0, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_FINISH, 32'd0, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_FINISH, 32'd0, 6'd0, 4'd0));
        // long 0xff runs to saturate the outstanding count
        for (int i = 0; i < 40; i++)
            add_cmd(mk(cbte_pkg::CMD_BYPASS, 32'hffffffff, 6'd8, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_FINISH, 32'd0, 6'd0, 4'd0));
        add_cmd(mk(cbte_pkg::CMD_START, 32'hffffffff, 6'h3f, 4'hf));
        wait_idle();

        // walk the config through its extremes
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(cbte_pkg::CFG_LPM, ph == 3 ? 5'd0 : 5'd1);
            write_reg(cbte_pkg::CFG_MLDR,
                      ph == 0 ? 5'd1 : ph == 1 ? 5'd28 : ph == 2 ? 5'd0 : 5'd31);
            add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'hffffffff, 6'd0, 4'd0));
            add_cmd(mk(cbte_pkg::CMD_LEVEL, 32'd40, 6'd0, 4'd1));
            for (int i = 0; i < 20; i++) add_cmd(rand_cmd());
            add_cmd(mk(cbte_pkg::CMD_FINISH, 32'd0, 6'd0, 4'd0));
            if (ph == 1) begin
                // sender holds back until every byte is out
                while (pending_cmds.size() > 12) @(posedge i_clk);
                hold_off = 1'b1;
                while (cmd_ch.valid || expected_bytes.size() != 0) @(posedge i_clk);
                hold_off = 1'b0;
            end
            wait_idle();
        end

        if (mismatches == 0 && expected_bytes.size() == 0)
            $display("cabac_bypass_terminate_encoder_tb passed");
        else
            $display("cabac_bypass_terminate_encoder_tb failed");
        $finish;
    end
endmodule

`default_nettype wire
